FILE: sv/heightmap_triangle_sample_defines.svh
// Assertion macros shared by the heightmap triangle sampler checkers.
// No dependencies; clock and reset names follow the block's ports.
`ifndef HEIGHTMAP_TRIANGLE_SAMPLE_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLE_DEFINES_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define HTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("heightmap sampler check failed");

// A stalled beat keeps its payload until it is taken.
`define HTS_ASSERT_HOLD(lbl, vld, rdy, sig) \
  `HTS_ASSERT(lbl, ((vld) && !(rdy)) |=> $stable(sig))

`endif

FILE: sv/htri_pkg.sv
// Shared types and constants for the heightmap triangle sampler.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package htri_pkg;

  // grid and number formats
  localparam int MAP_SIDE_DEF = 64;
  localparam int HEIGHT_W     = 16;
  localparam int FRAC_W       = 8;
  localparam int CELL_W       = 6;
  localparam int QUERY_W      = 14;
  localparam int CX_W         = QUERY_W - FRAC_W;
  localparam int OUT_W        = HEIGHT_W + FRAC_W;

  // interpolation arithmetic
  localparam int DIFF_W = HEIGHT_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;
  localparam int ACC_W  = PROD_W + 1;

  // size registers
  localparam int                  CFG_W     = 7;
  localparam int                  CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;
  localparam logic [CFG_W-1:0]     SIZE_RST = 7'd64;

  // item kinds carried in tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int IN_TDATA_W  = 2 * CELL_W + HEIGHT_W + 2 * QUERY_W;
  localparam int OUT_TDATA_W = OUT_W;

  // input beat payload, lowest field in the lowest bits
  typedef struct packed {
    logic [QUERY_W-1:0]  query_y;
    logic [QUERY_W-1:0]  query_x;
    logic [HEIGHT_W-1:0] height_value;
    logic [CELL_W-1:0]   cell_y;
    logic [CELL_W-1:0]   cell_x;
  } item_t;

  // sequencer to datapath: corner capture strobes and the fractions
  typedef struct packed {
    logic              cap_a;
    logic              cap_p;
    logic              cap_c;
    logic              abc;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } corner_ctl_t;

  // sequencer to output stage: result hand-off
  typedef struct packed {
    logic vld;
    logic status;
    logic use_interp;
  } push_t;

endpackage

FILE: sv/heightmap_triangle_sample.sv
// Heightmap triangle sampler: a MAP_SIDE x MAP_SIDE grid of signed heights
// in one single-port RAM, filled by write beats (tuser 0) and sampled by query
// beats (tuser 1) that return the height on the cell's triangle plane with 8
// fraction bits. A query runs through ST_RD_P, ST_RD_C, ST_CAP_C and ST_PUSH
// before the next accept: the three corner reads share the one RAM port, one
// per cycle, and the plane sum needs a second multiply step; a write or a
// rejected query goes straight to ST_PUSH. Results leave through an output
// register, so the next beat is taken while a result waits. The grid needs no
// clearing pass after reset; it must be written before it is sampled.
// Depends on htri_pkg, htri_ram, htri_ctrl and htri_interp.
`timescale 1ns / 1ps

module heightmap_triangle_sample #(
  parameter int MAP_SIDE = htri_pkg::MAP_SIDE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // size registers
  input  logic                                cfg_we_i,
  input  logic [htri_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [htri_pkg::CFG_W-1:0]          cfg_wdata_i,
  // input beats
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // cell_x[5:0], cell_y[11:6], height_value[27:12], query_x[41:28], query_y[55:42]
  input  logic [htri_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // func[0]
  input  logic                                s_axis_tuser_i,
  // result beats
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // height_out[23:0]
  output logic [htri_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // status[0]
  output logic                                m_axis_tuser_o
);

  localparam int AW = $clog2(MAP_SIDE * MAP_SIDE);

  logic [htri_pkg::CFG_W-1:0]    cols_q, rows_q;
  htri_pkg::item_t               item;
  logic                          out_free;
  logic                          ram_en, ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [htri_pkg::HEIGHT_W-1:0] ram_wdata, ram_rdata;
  htri_pkg::corner_ctl_t         corner;
  htri_pkg::push_t               push;
  logic [htri_pkg::OUT_W-1:0]    res;
  logic                          m_valid_q;
  logic [htri_pkg::OUT_W-1:0]    m_data_q;
  logic                          m_user_q;

  assign item = s_axis_tdata_i;

  // grid size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= htri_pkg::SIZE_RST;
      rows_q <= htri_pkg::SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        htri_pkg::CFG_COLS: cols_q <= cfg_wdata_i;
        htri_pkg::CFG_ROWS: rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  htri_ctrl #(
    .MAP_SIDE (MAP_SIDE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_func_i    (s_axis_tuser_i),
    .item_i      (item),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .out_free_i  (out_free),
    .s_ready_o   (s_axis_tready_o),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .corner_o    (corner),
    .push_o      (push)
  );

  htri_ram #(
    .WIDTH (htri_pkg::HEIGHT_W),
    .DEPTH (MAP_SIDE * MAP_SIDE)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  htri_interp u_interp (
    .clk_i    (clk_i),
    .corner_i (corner),
    .rdata_i  (ram_rdata),
    .res_o    (res)
  );

  // output register; writes and rejected queries report zero height
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else if (push.vld) begin
      m_valid_q <= 1'b1;
      m_data_q  <= push.use_interp ? res : '0;
      m_user_q  <= push.status;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

FILE: sv/htri_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies beyond htri_pkg for default sizes.
`timescale 1ns / 1ps

module htri_ram #(
  parameter int WIDTH = htri_pkg::HEIGHT_W,
  parameter int DEPTH = htri_pkg::MAP_SIDE_DEF * htri_pkg::MAP_SIDE_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one access per cycle: write, or read into a registered output
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/htri_ctrl.sv
// Sequencer of the heightmap sampler: accepts beats, drives the height RAM
// port and hands results on. Depends on htri_pkg.
`timescale 1ns / 1ps

module htri_ctrl #(
  parameter int MAP_SIDE = htri_pkg::MAP_SIDE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  input  logic                               s_func_i,
  input  htri_pkg::item_t                    item_i,
  input  logic [htri_pkg::CFG_W-1:0]         cols_i,
  input  logic [htri_pkg::CFG_W-1:0]         rows_i,
  input  logic                               out_free_i,
  output logic                               s_ready_o,
  output logic                               ram_en_o,
  output logic                               ram_we_o,
  output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] ram_addr_o,
  output logic [htri_pkg::HEIGHT_W-1:0]      ram_wdata_o,
  output htri_pkg::corner_ctl_t              corner_o,
  output htri_pkg::push_t                    push_o
);

  localparam int AW = $clog2(MAP_SIDE * MAP_SIDE);
  localparam int FW = htri_pkg::FRAC_W;
  localparam int CW = htri_pkg::CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_P,
    ST_RD_C,
    ST_CAP_C,
    ST_PUSH
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   base_q, base_d;
  logic            abc_q, abc_d;
  logic [FW-1:0]   fx_q, fx_d;
  logic [FW-1:0]   fy_q, fy_d;
  logic            status_q, status_d;
  logic            use_q, use_d;

  logic [htri_pkg::CX_W-1:0] cx, cy;
  logic [FW-1:0]             fx, fy;
  logic [CW-1:0]             cols_eff, rows_eff;
  logic                      reject, wr_in_range, accept;
  logic [AW-1:0]             q_addr, w_addr;

  // split the query point into cell and fraction
  assign cx = item_i.query_x[htri_pkg::QUERY_W-1:FW];
  assign cy = item_i.query_y[htri_pkg::QUERY_W-1:FW];
  assign fx = item_i.query_x[FW-1:0];
  assign fy = item_i.query_y[FW-1:0];

  // sizes above the grid act as the grid side
  assign cols_eff = (32'(cols_i) > MAP_SIDE) ? CW'(MAP_SIDE) : cols_i;
  assign rows_eff = (32'(rows_i) > MAP_SIDE) ? CW'(MAP_SIDE) : rows_i;

  // outside the mesh when the far corner is not inside the grid in use
  assign reject = ((CW'(cx) + CW'(1)) >= cols_eff) || ((CW'(cy) + CW'(1)) >= rows_eff);

  assign wr_in_range = (32'(item_i.cell_x) < MAP_SIDE) && (32'(item_i.cell_y) < MAP_SIDE);

  assign q_addr = AW'(cy) * AW'(MAP_SIDE) + AW'(cx);
  assign w_addr = AW'(item_i.cell_y) * AW'(MAP_SIDE) + AW'(item_i.cell_x);

  assign accept    = s_valid_i && (state_q == ST_IDLE);
  assign s_ready_o = (state_q == ST_IDLE);

  // next state, RAM port and strobes
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    abc_d       = abc_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    status_d    = status_q;
    use_d       = use_q;
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = base_q;
    ram_wdata_o = item_i.height_value;
    corner_o    = '0;
    push_o      = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PUSH;
          if (s_func_i == htri_pkg::FUNC_WRITE) begin
            ram_en_o   = wr_in_range;
            ram_we_o   = 1'b1;
            ram_addr_o = w_addr;
            status_d   = 1'b0;
            use_d      = 1'b0;
          end else if (reject) begin
            status_d = 1'b1;
            use_d    = 1'b0;
          end else begin
            // corner A is read right away
            ram_en_o   = 1'b1;
            ram_addr_o = q_addr;
            base_d     = q_addr;
            abc_d      = (fy <= fx);
            fx_d       = fx;
            fy_d       = fy;
            status_d   = 1'b0;
            use_d      = 1'b1;
            state_d    = ST_RD_P;
          end
        end
      end
      ST_RD_P: begin
        // middle corner: B for triangle ABC, D for ACD
        ram_en_o       = 1'b1;
        ram_addr_o     = base_q + (abc_q ? AW'(1) : AW'(MAP_SIDE));
        corner_o.cap_a = 1'b1;
        state_d        = ST_RD_C;
      end
      ST_RD_C: begin
        ram_en_o       = 1'b1;
        ram_addr_o     = base_q + AW'(MAP_SIDE) + AW'(1);
        corner_o.cap_p = 1'b1;
        state_d        = ST_CAP_C;
      end
      ST_CAP_C: begin
        corner_o.cap_c = 1'b1;
        state_d        = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free_i) begin
          push_o.vld = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    corner_o.abc      = abc_q;
    corner_o.fx       = fx_q;
    corner_o.fy       = fy_q;
    push_o.status     = status_q;
    push_o.use_interp = use_q;
  end

  // state and held query context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      base_q   <= '0;
      abc_q    <= 1'b0;
      fx_q     <= '0;
      fy_q     <= '0;
      status_q <= 1'b0;
      use_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      abc_q    <= abc_d;
      fx_q     <= fx_d;
      fy_q     <= fy_d;
      status_q <= status_d;
      use_q    <= use_d;
    end
  end

endmodule

FILE: sv/htri_interp.sv
// Plane interpolation datapath: collects three corner heights from the
// RAM read port and forms the height in two multiply steps. Depends on htri_pkg.
`timescale 1ns / 1ps

module htri_interp (
  input  logic                          clk_i,
  input  htri_pkg::corner_ctl_t         corner_i,
  input  logic [htri_pkg::HEIGHT_W-1:0] rdata_i,
  output logic [htri_pkg::OUT_W-1:0]    res_o
);

  localparam int HW = htri_pkg::HEIGHT_W;
  localparam int FW = htri_pkg::FRAC_W;

  logic signed [HW-1:0]               h0_q, h1_q, h2_q;
  logic signed [htri_pkg::PROD_W-1:0] p1_q, p2;
  logic signed [htri_pkg::DIFF_W-1:0] d_lo, d_hi;
  logic        [FW-1:0]               f_lo, f_hi;
  logic signed [htri_pkg::OUT_W-1:0]  base;
  logic signed [htri_pkg::ACC_W-1:0]  acc;

  // h0 = A, h1 = B or D, h2 = C; both triangles reduce to
  // A*2^F + d_lo*f_lo + d_hi*f_hi with the fractions swapped for ACD
  assign d_lo = htri_pkg::DIFF_W'(h1_q) - htri_pkg::DIFF_W'(h0_q);
  assign d_hi = htri_pkg::DIFF_W'(h2_q) - htri_pkg::DIFF_W'(h1_q);
  assign f_lo = corner_i.abc ? corner_i.fx : corner_i.fy;
  assign f_hi = corner_i.abc ? corner_i.fy : corner_i.fx;

  // corner capture and first product
  always_ff @(posedge clk_i) begin
    if (corner_i.cap_a) begin
      h0_q <= rdata_i;
    end
    if (corner_i.cap_p) begin
      h1_q <= rdata_i;
    end
    if (corner_i.cap_c) begin
      h2_q <= rdata_i;
      p1_q <= htri_pkg::PROD_W'(d_lo) * htri_pkg::PROD_W'($signed({1'b0, f_lo}));
    end
  end

  // second product and sum, registered by the output stage
  assign p2   = htri_pkg::PROD_W'(d_hi) * htri_pkg::PROD_W'($signed({1'b0, f_hi}));
  assign base = {h0_q, {FW{1'b0}}};
  assign acc  = htri_pkg::ACC_W'(base) + htri_pkg::ACC_W'(p1_q) + htri_pkg::ACC_W'(p2);
  assign res_o = acc[htri_pkg::OUT_W-1:0];

endmodule

FILE: sv/htri_checker.sv
// Port-level checks for the heightmap triangle sampler, bound to the top.
// Depends on htri_pkg and heightmap_triangle_sample_defines.svh.
`timescale 1ns / 1ps
`include "heightmap_triangle_sample_defines.svh"

module htri_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [htri_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);

  // a result beat is not withdrawn while stalled
  `HTS_ASSERT(a_out_valid_held, (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)

  // a stalled result keeps its height
  `HTS_ASSERT_HOLD(a_out_data_held, m_axis_tvalid_o, m_axis_tready_i, m_axis_tdata_o)

  // every accepted beat makes the block busy, with ready low in the next cycle
  `HTS_ASSERT(a_busy_after_accept, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)

  // a point outside the mesh reports zero height
  `HTS_ASSERT(a_reject_zero, (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))

endmodule

bind heightmap_triangle_sample htri_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: tb/sv/heightmap_triangle_sample_tb.sv
// Self-checking bench for heightmap_triangle_sample: directed table, then random phases.
// Results are checked against a grid model of written points or a row's known value.
// Depends on htri_pkg and the heightmap_triangle_sample RTL.
`timescale 1ns / 1ps

module heightmap_triangle_sample_tb;
  import htri_pkg::*;

  localparam int SIDE        = 64;
  localparam int ITEM_GOAL   = 1800;
  localparam int PHASE_ITEMS = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [OUT_W-1:0] height;
    logic             status;
  } sample_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_SIZE} row_kind_e;

  // a: cell_x / query_x / cols, b: cell_y / query_y / rows
  typedef struct {
    row_kind_e kind;
    int        a;
    int        b;
    int        h;
    bit        known;
    sample_t   typed;
  } dir_row_t;

  // DUT signals
  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx   = CFG_COLS;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = FUNC_WRITE;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  // model state
  logic signed [HEIGHT_W-1:0] grid [SIDE*SIDE];
  bit                         grid_set [SIDE*SIDE];
  int                         cols_cfg = int'(SIZE_RST);
  int                         rows_cfg = int'(SIZE_RST);

  sample_t  pending_heights[$];
  dir_row_t steps[$];
  int       errors     = 0;
  int       items_sent = 0;
  int       rx_count   = 0;
  int       tx_burst   = 0;
  int       rx_burst   = 0;
  int       idle_cnt   = 0;

  heightmap_triangle_sample i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #1 clk_i = ~clk_i;

  // sizes above the grid act as the grid side
  function automatic int eff_size(int s);
    return (s > SIDE) ? SIDE : s;
  endfunction

  function automatic bit in_mesh(int qx, int qy);
    int c;
    int r;
    c = eff_size(cols_cfg);
    r = eff_size(rows_cfg);
    if (c < 2 || r < 2) return 1'b0;
    return ((qx >> FRAC_W) < c - 1) && ((qy >> FRAC_W) < r - 1);
  endfunction

  // plane interpolation on the selected triangle; writes update the grid
  function automatic sample_t sample_height(logic fn, item_t it);
    sample_t s;
    int idx;
    int cx;
    int cy;
    int fx;
    int fy;
    int ha;
    int hb;
    int hc;
    int hd;
    int acc;
    s = '0;
    if (fn == FUNC_WRITE) begin
      idx = int'(it.cell_y) * SIDE + int'(it.cell_x);
      grid[idx]     = it.height_value;
      grid_set[idx] = 1'b1;
    end else if (!in_mesh(int'(it.query_x), int'(it.query_y))) begin
      s.status = 1'b1;
    end else begin
      cx = int'(it.query_x) >> FRAC_W;
      cy = int'(it.query_y) >> FRAC_W;
      fx = int'(it.query_x[FRAC_W-1:0]);
      fy = int'(it.query_y[FRAC_W-1:0]);
      ha = int'(grid[cy * SIDE + cx]);
      hb = int'(grid[cy * SIDE + cx + 1]);
      hc = int'(grid[(cy + 1) * SIDE + cx + 1]);
      hd = int'(grid[(cy + 1) * SIDE + cx]);
      if (fy <= fx) acc = ha * (1 << FRAC_W) + (hb - ha) * fx + (hc - hb) * fy;
      else          acc = ha * (1 << FRAC_W) + (hc - hd) * fx + (hd - ha) * fy;
      s.height = acc[OUT_W-1:0];
    end
    return s;
  endfunction

  // per-beat gap, with occasional back-to-back stretches
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [HEIGHT_W-1:0] rand_height();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return HEIGHT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic item_t rand_payload();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[IN_TDATA_W-1:0];
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return SIDE;
      4:       return 127;
      5:       return SIDE - 1;
      default: return $urandom_range(2, 127);
    endcase
  endfunction

  // directed table builders
  function automatic void add_write(int x, int y, int h);
    dir_row_t r;
    r = '{kind: ROW_WRITE, a: x, b: y, h: h, known: 1'b1, typed: '0};
    steps.push_back(r);
  endfunction

  function automatic void add_query(int qx, int qy, bit known, int h, logic st);
    dir_row_t r;
    sample_t  t;
    t.height = h[OUT_W-1:0];
    t.status = st;
    r = '{kind: ROW_QUERY, a: qx, b: qy, h: 0, known: known, typed: t};
    steps.push_back(r);
  endfunction

  function automatic void add_size(int c, int r);
    dir_row_t d;
    d = '{kind: ROW_SIZE, a: c, b: r, h: 0, known: 1'b0, typed: '0};
    steps.push_back(d);
  endfunction

  // offer one beat after a random gap; predict at the accepting edge
  task automatic send_beat(logic fn, item_t it, bit known, sample_t typed);
    int      gap;
    sample_t pred;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    s_tuser  <= fn;
    do @(posedge clk_i); while (!s_tready);
    pred = sample_height(fn, it);
    pending_heights.push_back(known ? typed : pred);
    items_sent++;
  endtask

  task automatic send_write(int x, int y, logic [HEIGHT_W-1:0] h);
    item_t it;
    it              = rand_payload();
    it.cell_x       = x[CELL_W-1:0];
    it.cell_y       = y[CELL_W-1:0];
    it.height_value = h;
    send_beat(FUNC_WRITE, it, 1'b0, '0);
  endtask

  task automatic send_query(int qx, int qy);
    item_t it;
    it         = rand_payload();
    it.query_x = qx[QUERY_W-1:0];
    it.query_y = qy[QUERY_W-1:0];
    send_beat(FUNC_QUERY, it, 1'b0, '0);
  endtask

  // sender pause: nothing offered until every result is back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_sizes(int c, int r);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_COLS;
    cfg_wdata <= c[CFG_W-1:0];
    @(posedge clk_i);
    cols_cfg  = c;
    cfg_idx   <= CFG_ROWS;
    cfg_wdata <= r[CFG_W-1:0];
    @(posedge clk_i);
    rows_cfg  = r;
    cfg_we    <= 1'b0;
  endtask

  // make sure every corner of a cell holds a written height
  task automatic write_missing(int cx, int cy);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        if (!grid_set[(cy + dy) * SIDE + cx + dx]) send_write(cx + dx, cy + dy, rand_height());
      end
    end
  endtask

  task automatic random_item();
    int sel;
    int c;
    int r;
    int qx;
    int qy;
    sel = $urandom_range(0, 9);
    c   = eff_size(cols_cfg);
    r   = eff_size(rows_cfg);
    if (sel < 2) begin
      send_write($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1), rand_height());
    end else begin
      if (sel < 8 && c >= 2 && r >= 2) begin
        qx = ($urandom_range(0, c - 2) << FRAC_W) | $urandom_range(0, 255);
        qy = ($urandom_range(0, r - 2) << FRAC_W) | $urandom_range(0, 255);
      end else begin
        qx = $urandom_range(0, 16383);
        qy = $urandom_range(0, 16383);
      end
      if (in_mesh(qx, qy)) begin
        write_missing(qx >> FRAC_W, qy >> FRAC_W);
        // refresh one corner now and then so the cell content keeps moving
        if ($urandom_range(0, 3) == 0)
          send_write((qx >> FRAC_W) + $urandom_range(0, 1),
                     (qy >> FRAC_W) + $urandom_range(0, 1), rand_height());
      end
      send_query(qx, qy);
    end
  endtask

  // result side: random gaps, one long hold-off to back up the input
  initial begin
    int      gap;
    bit      held;
    sample_t want;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(rx_burst);
      if (!held && rx_count >= HOLD_AT) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      rx_count++;
      if (pending_heights.size() == 0) begin
        $display("%0t: result beat with nothing expected, height %h status %b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_heights.pop_front();
        if (m_tdata !== want.height) begin
          $display("%0t: height mismatch, expected %h, got %h", $time, want.height, m_tdata);
          errors++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %b, got %b", $time, want.status, m_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    dir_row_t row;
    item_t    it;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    add_query(16383, 0, 1'b1, 0, 1'b1);           // last column is outside the mesh
    add_query(0, 63 << FRAC_W, 1'b1, 0, 1'b1);    // last row is outside the mesh
    add_write(0, 0, 32767);
    add_write(1, 0, -32768);
    add_write(1, 1, 32767);
    add_write(0, 1, -32768);
    add_query(0, 0, 1'b1, 24'h7FFF00, 1'b0);      // corner A, zero fraction
    add_query(255, 0, 1'b0, 0, 1'b0);
    add_query(255, 255, 1'b0, 0, 1'b0);           // fy == fx stays on ABC
    add_query(0, 128, 1'b0, 0, 1'b0);
    add_query(64, 65, 1'b0, 0, 1'b0);             // just above the diagonal
    add_write(62, 62, -1);
    add_write(63, 62, 12345);
    add_write(63, 63, -20000);
    add_write(62, 63, 0);
    add_query((62 << FRAC_W) | 255, (62 << FRAC_W) | 127, 1'b0, 0, 1'b0);
    add_size(0, 64);
    add_query(0, 0, 1'b1, 0, 1'b1);               // zero columns reject all
    add_size(1, 64);
    add_query(0, 0, 1'b1, 0, 1'b1);               // one column rejects all
    add_size(2, 2);
    add_query(128, 200, 1'b0, 0, 1'b0);
    add_query(256, 0, 1'b1, 0, 1'b1);
    add_size(127, 127);                           // clamps to the grid side
    add_query((62 << FRAC_W) | 17, (62 << FRAC_W) | 200, 1'b0, 0, 1'b0);
    add_query(63 << FRAC_W, 0, 1'b1, 0, 1'b1);
    add_size(64, 0);
    add_query(0, 0, 1'b1, 0, 1'b1);

    foreach (steps[i]) begin
      row = steps[i];
      it  = '0;
      case (row.kind)
        ROW_SIZE: begin
          wait_idle();
          set_sizes(row.a, row.b);
        end
        ROW_WRITE: begin
          it.cell_x       = row.a[CELL_W-1:0];
          it.cell_y       = row.b[CELL_W-1:0];
          it.height_value = row.h[HEIGHT_W-1:0];
          send_beat(FUNC_WRITE, it, row.known, row.typed);
        end
        default: begin
          it.query_x = row.a[QUERY_W-1:0];
          it.query_y = row.b[QUERY_W-1:0];
          send_beat(FUNC_QUERY, it, row.known, row.typed);
        end
      endcase
    end

    // random phases, each under its own grid size
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      set_sizes(pick_size(), pick_size());
      for (int n = 0; n < PHASE_ITEMS && items_sent < ITEM_GOAL; n++) random_item();
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/htri_pkg.sv
sv/htri_ram.sv
sv/htri_ctrl.sv
sv/htri_interp.sv
sv/heightmap_triangle_sample.sv
sv/htri_checker.sv
tb/sv/heightmap_triangle_sample_tb.sv
